// ----- design/rne_pkg.sv -----
`timescale 1ns / 1ps

package rne_pkg;

    localparam int unsigned ValueWidth  = 12;
    localparam int unsigned LetterWidth = 7;
    localparam int unsigned DigitWidth  = 4;
    localparam int unsigned NumDigits   = 4;
    localparam logic [ValueWidth-1:0] ValueMax = 12'd3999;

    localparam logic [LetterWidth-1:0] LetterI = 7'h49;
    localparam logic [LetterWidth-1:0] LetterV = 7'h56;
    localparam logic [LetterWidth-1:0] LetterX = 7'h58;
    localparam logic [LetterWidth-1:0] LetterL = 7'h4C;
    localparam logic [LetterWidth-1:0] LetterC = 7'h43;
    localparam logic [LetterWidth-1:0] LetterD = 7'h44;
    localparam logic [LetterWidth-1:0] LetterM = 7'h4D;
    localparam logic [LetterWidth-1:0] LetterNone = 7'h00;

    localparam logic [1:0] PosUnits     = 2'd0;
    localparam logic [1:0] PosTens      = 2'd1;
    localparam logic [1:0] PosHundreds  = 2'd2;
    localparam logic [1:0] PosThousands = 2'd3;

    typedef struct packed {
        logic                                  zero;
        logic                                  oor;
        logic [NumDigits-1:0][DigitWidth-1:0]  digit;
    } item_t;

    typedef struct packed {
        logic [DigitWidth-1:0] digit;
        logic [ValueWidth-1:0] rem;
    } split_t;

    // Largest multiple of step, up to nine times step, not above r, found by parallel compares.
    function automatic split_t split_dec(input logic [ValueWidth-1:0] r,
                                         input logic [9:0] step);
        split_t res;
        logic [13:0] prod;
        res.digit = '0;
        res.rem   = r;
        for (int k = 1; k <= 9; k++) begin
            prod = 14'(k) * {4'b0, step};
            if ({2'b0, r} >= prod) begin
                res.digit = DigitWidth'(k);
                res.rem   = r - prod[ValueWidth-1:0];
            end
        end
        return res;
    endfunction

    function automatic logic [2:0] digit_len(input logic [DigitWidth-1:0] d);
        logic [2:0] len;
        case (d)
            4'd1, 4'd5: len = 3'd1;
            4'd2, 4'd4, 4'd6, 4'd9: len = 3'd2;
            4'd3, 4'd7: len = 3'd3;
            4'd8: len = 3'd4;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [1:0] top_set(input logic [NumDigits-1:0] m);
        logic [1:0] p;
        p = PosUnits;
        if (m[1]) p = PosTens;
        if (m[2]) p = PosHundreds;
        if (m[3]) p = PosThousands;
        return p;
    endfunction

    function automatic logic [LetterWidth-1:0] numeral(input logic [1:0] pos,
                                                       input logic [DigitWidth-1:0] d,
                                                       input logic [1:0] j);
        logic [LetterWidth-1:0] one;
        logic [LetterWidth-1:0] five;
        logic [LetterWidth-1:0] ten;
        logic [LetterWidth-1:0] ch;
        case (pos)
            PosUnits: begin
                one = LetterI; five = LetterV; ten = LetterX;
            end
            PosTens: begin
                one = LetterX; five = LetterL; ten = LetterC;
            end
            PosHundreds: begin
                one = LetterC; five = LetterD; ten = LetterM;
            end
            default: begin
                one = LetterM; five = LetterM; ten = LetterM;
            end
        endcase
        if (d == 4'd4) begin
            ch = (j == 2'd0) ? one : five;
        end else if (d == 4'd9) begin
            ch = (j == 2'd0) ? one : ten;
        end else if (d inside {[4'd5:4'd8]}) begin
            ch = (j == 2'd0) ? five : one;
        end else begin
            ch = one;
        end
        return ch;
    endfunction

endpackage

// ----- design/rne_front.sv -----
`timescale 1ns / 1ps

module rne_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rne_pkg::ValueWidth-1:0]     s_value,
    output logic                               item_valid,
    input  logic                               item_ready,
    output rne_pkg::item_t                     item
);

    logic                              a_valid_reg;
    logic                              a_zero_reg;
    logic                              a_oor_reg;
    logic [rne_pkg::DigitWidth-1:0]    a_d3_reg;
    logic [9:0]                        a_rem_reg;
    logic                              b_valid_reg;
    logic                              b_zero_reg;
    logic                              b_oor_reg;
    logic [rne_pkg::DigitWidth-1:0]    b_d3_reg;
    logic [rne_pkg::DigitWidth-1:0]    b_d2_reg;
    logic [6:0]                        b_rem_reg;
    logic                              b_ready;
    logic                              in_zero;
    logic                              in_oor;
    rne_pkg::split_t                   sp_th;
    rne_pkg::split_t                   sp_hu;
    rne_pkg::split_t                   sp_te;

    assign b_ready = !b_valid_reg || item_ready;
    assign s_ready = !a_valid_reg || b_ready;

    assign in_zero = (s_value == '0);
    assign in_oor  = (s_value > rne_pkg::ValueMax);
    assign sp_th   = rne_pkg::split_dec(s_value, 10'd1000);
    assign sp_hu   = rne_pkg::split_dec({2'b0, a_rem_reg}, 10'd100);
    assign sp_te   = rne_pkg::split_dec({5'b0, b_rem_reg}, 10'd10);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (s_valid && s_ready) begin
                a_zero_reg <= in_zero;
                a_oor_reg  <= in_oor;
                a_d3_reg   <= in_oor ? '0 : sp_th.digit;
                a_rem_reg  <= in_oor ? '0 : sp_th.rem[9:0];
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (a_valid_reg && b_ready) begin
                b_zero_reg <= a_zero_reg;
                b_oor_reg  <= a_oor_reg;
                b_d3_reg   <= a_d3_reg;
                b_d2_reg   <= sp_hu.digit;
                b_rem_reg  <= sp_hu.rem[6:0];
            end
        end
    end

    assign item_valid     = b_valid_reg;
    assign item.zero      = b_zero_reg;
    assign item.oor       = b_oor_reg;
    assign item.digit[3]  = b_d3_reg;
    assign item.digit[2]  = b_d2_reg;
    assign item.digit[1]  = sp_te.digit;
    assign item.digit[0]  = sp_te.rem[rne_pkg::DigitWidth-1:0];

endmodule

// ----- design/rne_queue.sv -----
`timescale 1ns / 1ps

module rne_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rne_pkg::item_t   in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output rne_pkg::item_t   out_item
);

    rne_pkg::item_t  mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                mem_reg[wr_ptr_reg] <= in_item;
                wr_ptr_reg          <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

// ----- design/rne_back.sv -----
`timescale 1ns / 1ps

module rne_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                head_valid,
    output logic                                head_pop,
    input  rne_pkg::item_t                      head,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rne_pkg::LetterWidth-1:0]     m_letter,
    output logic                                m_last,
    output logic                                m_empty_res,
    output logic                                m_out_of_range
);

    logic                                 m_valid_reg;
    logic [rne_pkg::LetterWidth-1:0]      m_letter_reg;
    logic                                 m_last_reg;
    logic                                 m_empty_reg;
    logic                                 m_oor_reg;
    logic                                 started_reg;
    logic [1:0]                           pos_reg;
    logic [1:0]                           j_reg;
    logic [rne_pkg::NumDigits-1:0]        nz;
    logic [rne_pkg::NumDigits-1:0]        below;
    logic [1:0]                           cur_pos;
    logic [rne_pkg::DigitWidth-1:0]       cur_d;
    logic [2:0]                           cur_len;
    logic                                 digit_done;
    logic                                 special;
    logic                                 fire;
    logic                                 final_res;

    always_comb begin
        for (int i = 0; i < rne_pkg::NumDigits; i++) begin
            nz[i] = (head.digit[i] != '0);
        end
    end

    assign cur_pos    = started_reg ? pos_reg : rne_pkg::top_set(nz);
    assign cur_d      = head.digit[cur_pos];
    assign cur_len    = rne_pkg::digit_len(cur_d);
    assign digit_done = (({1'b0, j_reg} + 3'd1) == cur_len);

    always_comb begin
        case (cur_pos)
            rne_pkg::PosThousands: below = nz & 4'b0111;
            rne_pkg::PosHundreds:  below = nz & 4'b0011;
            rne_pkg::PosTens:      below = nz & 4'b0001;
            default:               below = 4'b0000;
        endcase
    end

    assign special   = head.zero || head.oor;
    assign fire      = head_valid && (!m_valid_reg || m_ready);
    assign final_res = special || (digit_done && (below == '0));
    assign head_pop  = fire && final_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            started_reg <= 1'b0;
            pos_reg     <= rne_pkg::PosUnits;
            j_reg       <= 2'd0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg  <= 1'b1;
                m_last_reg   <= final_res;
                m_empty_reg  <= head.zero;
                m_oor_reg    <= head.oor;
                m_letter_reg <= special ? rne_pkg::LetterNone
                                        : rne_pkg::numeral(cur_pos, cur_d, j_reg);
                if (final_res) begin
                    started_reg <= 1'b0;
                    j_reg       <= 2'd0;
                end else if (digit_done) begin
                    started_reg <= 1'b1;
                    pos_reg     <= rne_pkg::top_set(below);
                    j_reg       <= 2'd0;
                end else begin
                    started_reg <= 1'b1;
                    pos_reg     <= cur_pos;
                    j_reg       <= j_reg + 2'd1;
                end
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_letter       = m_letter_reg;
    assign m_last         = m_last_reg;
    assign m_empty_res    = m_empty_reg;
    assign m_out_of_range = m_oor_reg;

endmodule

// ----- design/roman_numeral_encoder.sv -----
// A first result passes front registers A and B, the queue, then the output register.
// Throughput: one result per cycle while m_ready holds; a request has 1 up to 15 results
// (3888); the back end's single output register sets this rate.
// A two-stage front end and a two-entry queue keep requests flowing meanwhile.
// Reset: aresetn is synchronous and active low; it empties all stages, the queue and
// the output register.
`timescale 1ns / 1ps

module roman_numeral_encoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rne_pkg::ValueWidth-1:0]      s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rne_pkg::LetterWidth-1:0]     m_letter,
    output logic                                m_last,
    output logic                                m_empty_res,
    output logic                                m_out_of_range
);

    logic             fq_valid;
    logic             fq_ready;
    rne_pkg::item_t   fq_item;
    logic             qb_valid;
    logic             qb_pop;
    rne_pkg::item_t   qb_item;

    rne_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .item_valid (fq_valid),
        .item_ready (fq_ready),
        .item       (fq_item)
    );

    rne_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_pop),
        .out_item  (qb_item)
    );

    rne_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (qb_valid),
        .head_pop       (qb_pop),
        .head           (qb_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_letter       (m_letter),
        .m_last         (m_last),
        .m_empty_res    (m_empty_res),
        .m_out_of_range (m_out_of_range)
    );

endmodule
